[hdl/assert_macros.svh]
// Assertion macros used by the receiver top level.
// No dependencies; define NO_ASSERTIONS to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

[hdl/srr_pkg.sv]
// Shared types and constants of the SLIP response receiver.
// No dependencies; the other files that use it refer to it by scoped names.
package srr_pkg;

    localparam int FRAME_CAPACITY_DEF = 128;
    localparam int DATA_CAPACITY_DEF  = 32;
    localparam int RUN_LIMIT          = 32;
    localparam int HEADER_BYTES       = 8;

    localparam logic [7:0] SLIP_END     = 8'hC0;
    localparam logic [7:0] SLIP_ESC     = 8'hDB;
    localparam logic [7:0] SLIP_ESC_END = 8'hDC;
    localparam logic [7:0] SLIP_ESC_ESC = 8'hDD;
    localparam logic [7:0] DIR_RESPONSE = 8'h01;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    localparam logic [7:0] EXPECTED_COMMAND_RST     = 8'd8;
    localparam logic       EXPECT_STATUS_RST        = 1'b1;
    localparam logic [5:0] EXPECTED_DATA_LENGTH_RST = 6'd0;
    localparam logic [3:0] MAX_ATTEMPTS_RST         = 4'd8;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_EXPECTED_COMMAND     = 2'd0,
        CFG_EXPECT_STATUS        = 2'd1,
        CFG_EXPECTED_DATA_LENGTH = 2'd2,
        CFG_MAX_ATTEMPTS         = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        VERDICT_ACCEPTED  = 2'd0,
        VERDICT_TOO_SHORT = 2'd1,
        VERDICT_NO_STATUS = 2'd2,
        VERDICT_MISMATCH  = 2'd3
    } verdict_t;

    typedef struct packed {
        logic [7:0] expected_command;
        logic       expect_status;
        logic [5:0] expected_data_length;
        logic [3:0] max_attempts;
    } cfg_t;

    // Everything a frame's results share, fixed when the frame closes.
    typedef struct packed {
        verdict_t    verdict;
        logic        gave_up;
        logic [7:0]  direction;
        logic [7:0]  command;
        logic [15:0] size_field;
        logic [31:0] value_field;
        logic        status_present;
        logic [7:0]  status_first;
        logic [7:0]  status_second;
        logic [5:0]  data_count;
    } close_t;

endpackage

[hdl/srr_rx_if.sv]
// Byte input channel of the receiver.
// Depends on nothing.
interface srr_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

[hdl/srr_res_if.sv]
// Result channel of the receiver: one item per copied data byte, or one if none was copied.
// Depends on nothing.
interface srr_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  verdict;
    logic        gave_up;
    logic [7:0]  direction;
    logic [7:0]  command;
    logic [15:0] size_field;
    logic [31:0] value_field;
    logic        status_present;
    logic [7:0]  status_first;
    logic [7:0]  status_second;
    logic [5:0]  data_count;
    logic [7:0]  data_byte;
    logic        last_of_run;

    modport source (
        output valid, output verdict, output gave_up, output direction, output command,
        output size_field, output value_field, output status_present,
        output status_first, output status_second, output data_count,
        output data_byte, output last_of_run, input ready
    );
    modport sink (
        input valid, input verdict, input gave_up, input direction, input command,
        input size_field, input value_field, input status_present,
        input status_first, input status_second, input data_count,
        input data_byte, input last_of_run, output ready
    );
endinterface

[hdl/srr_cfg_if.sv]
// Configuration write channel: register index and write data.
// Depends on srr_pkg for the field widths.
interface srr_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [srr_pkg::CFG_INDEX_W-1:0] index;
    logic [srr_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

[hdl/srr_ram.sv]
// Generic single-write, single-read RAM with a registered, enabled read port.
// No dependencies.
module srr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hdl/srr_deframer.sv]
// SLIP deframer: escape handling, header/status capture, data buffer writes
// and the verdict and attempt count at frame close. Depends on srr_pkg.
module srr_deframer #(
    parameter int FRAME_CAPACITY = srr_pkg::FRAME_CAPACITY_DEF,
    parameter int DATA_CAPACITY  = srr_pkg::DATA_CAPACITY_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  srr_pkg::cfg_t                    cfg,
    input  logic                             accept,
    input  logic [7:0]                       rx_byte,
    output logic                             close_valid,
    output srr_pkg::close_t                  close_info,
    output logic                             ram_we,
    output logic [$clog2(DATA_CAPACITY)-1:0] ram_waddr,
    output logic [7:0]                       ram_wdata
);

    localparam int BCW = $clog2(FRAME_CAPACITY + 1);
    localparam int AW  = $clog2(DATA_CAPACITY);
    localparam int W   = (BCW > 8) ? BCW : 8;
    localparam int COPY_MAX = (DATA_CAPACITY < srr_pkg::RUN_LIMIT) ?
                              DATA_CAPACITY : srr_pkg::RUN_LIMIT;

    logic           in_frame_reg, in_frame_next;
    logic           esc_reg, esc_next;
    logic [BCW-1:0] count_reg, count_next;
    logic [63:0]    header_reg, header_next;
    logic [15:0]    status_reg, status_next;
    logic [3:0]     attempt_reg, attempt_next;

    logic           keep;
    logic           store;
    logic [7:0]     kept_byte;
    logic [W-1:0]   cnt_w;
    logic [W-1:0]   off;
    logic [W-1:0]   edl_w;
    logic [W-1:0]   copied;
    logic [4:0]     attempt_inc;
    logic           too_short;
    logic           ok;

    assign cnt_w = W'(count_reg);
    assign off   = cnt_w - W'(srr_pkg::HEADER_BYTES);
    assign edl_w = W'(cfg.expected_data_length);

    // Framing and byte storage.
    always_comb
    begin
        in_frame_next = in_frame_reg;
        esc_next      = esc_reg;
        count_next    = count_reg;
        header_next   = header_reg;
        status_next   = status_reg;
        keep          = 1'b0;
        kept_byte     = rx_byte;
        close_valid   = 1'b0;

        if (accept)
        begin
            if (!in_frame_reg)
            begin
                if (rx_byte == srr_pkg::SLIP_END)
                begin
                    in_frame_next = 1'b1;
                    esc_next      = 1'b0;
                    count_next    = '0;
                    header_next   = '0;
                    status_next   = '0;
                end
            end
            else if (esc_reg)
            begin
                esc_next = 1'b0;
                keep     = 1'b1;
                if (rx_byte == srr_pkg::SLIP_ESC_END)
                begin
                    kept_byte = srr_pkg::SLIP_END;
                end
                else if (rx_byte == srr_pkg::SLIP_ESC_ESC)
                begin
                    kept_byte = srr_pkg::SLIP_ESC;
                end
            end
            else if (rx_byte == srr_pkg::SLIP_ESC)
            begin
                esc_next = 1'b1;
            end
            else if (rx_byte == srr_pkg::SLIP_END)
            begin
                // An empty frame is skipped and the opener still stands.
                if (count_reg != '0)
                begin
                    in_frame_next = 1'b0;
                    close_valid   = 1'b1;
                end
            end
            else
            begin
                keep = 1'b1;
            end
        end

        store = keep && (count_reg < BCW'(FRAME_CAPACITY));
        if (store)
        begin
            count_next = count_reg + BCW'(1);
            if (cnt_w < W'(srr_pkg::HEADER_BYTES))
            begin
                header_next[{count_reg[2:0], 3'b000} +: 8] = kept_byte;
            end
            else if (cfg.expect_status)
            begin
                if (off == edl_w)
                begin
                    status_next[7:0] = kept_byte;
                end
                else if (off == edl_w + W'(1))
                begin
                    status_next[15:8] = kept_byte;
                end
            end
        end
    end

    assign ram_we    = store && (cnt_w >= W'(srr_pkg::HEADER_BYTES)) &&
                       (off < W'(DATA_CAPACITY));
    assign ram_waddr = off[AW-1:0];
    assign ram_wdata = kept_byte;

    // Verdict, fields and copy length of the frame that closes now.
    always_comb
    begin
        close_info = '0;
        copied     = '0;
        too_short  = cnt_w < W'(srr_pkg::HEADER_BYTES);

        if (too_short)
        begin
            close_info.verdict = srr_pkg::VERDICT_TOO_SHORT;
        end
        else
        begin
            close_info.direction   = header_reg[7:0];
            close_info.command     = header_reg[15:8];
            close_info.size_field  = header_reg[31:16];
            close_info.value_field = header_reg[63:32];
            if (cfg.expect_status)
            begin
                if (off < edl_w + W'(2))
                begin
                    close_info.verdict = srr_pkg::VERDICT_NO_STATUS;
                end
                else
                begin
                    close_info.status_present = 1'b1;
                    close_info.status_first   = status_reg[7:0];
                    close_info.status_second  = status_reg[15:8];
                    copied                    = edl_w;
                end
            end
            else
            begin
                copied = off;
            end
        end

        if (copied > W'(COPY_MAX))
        begin
            copied = W'(COPY_MAX);
        end
        close_info.data_count = copied[5:0];

        ok = (close_info.direction == srr_pkg::DIR_RESPONSE) &&
             (close_info.command == cfg.expected_command) &&
             (!close_info.status_present || (status_reg == 16'h0000));
        if (!too_short && (close_info.verdict != srr_pkg::VERDICT_NO_STATUS))
        begin
            close_info.verdict = ok ? srr_pkg::VERDICT_ACCEPTED : srr_pkg::VERDICT_MISMATCH;
        end

        // A limit of zero behaves as one, since the incremented count is at least one.
        attempt_inc  = {1'b0, attempt_reg} + 5'd1;
        attempt_next = attempt_reg;
        if (close_valid)
        begin
            if (close_info.verdict == srr_pkg::VERDICT_ACCEPTED)
            begin
                attempt_next = '0;
            end
            else if (attempt_inc >= {1'b0, cfg.max_attempts})
            begin
                close_info.gave_up = 1'b1;
                attempt_next       = '0;
            end
            else
            begin
                attempt_next = attempt_inc[3:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            esc_reg      <= 1'b0;
            count_reg    <= '0;
            header_reg   <= '0;
            status_reg   <= '0;
            attempt_reg  <= '0;
        end
        else
        begin
            in_frame_reg <= in_frame_next;
            esc_reg      <= esc_next;
            count_reg    <= count_next;
            header_reg   <= header_next;
            status_reg   <= status_next;
            attempt_reg  <= attempt_next;
        end
    end

endmodule

[hdl/srr_run_gen.sv]
// Result run generator: walks the data buffer after a frame closes and feeds
// the output register. Depends on srr_pkg and srr_res_if.
module srr_run_gen #(
    parameter int DATA_CAPACITY = srr_pkg::DATA_CAPACITY_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             close_valid,
    input  srr_pkg::close_t                  close_info,
    output logic                             busy,
    output logic                             ram_re,
    output logic [$clog2(DATA_CAPACITY)-1:0] ram_raddr,
    input  logic [7:0]                       ram_rdata,
    srr_res_if.source                        res
);

    localparam int AW = $clog2(DATA_CAPACITY);

    srr_pkg::close_t sum_reg;
    logic            run_active_reg, run_active_next;
    logic [5:0]      idx_reg, idx_next;
    logic            rd_valid_reg, rd_valid_next;
    logic            rd_last_reg, rd_last_next;
    logic            out_valid_reg, out_valid_next;
    srr_pkg::close_t out_info_reg;
    logic [7:0]      out_byte_reg;
    logic            out_last_reg;

    logic [5:0]      run_len;
    logic            issue;
    logic            advance;

    // A frame with no copied data still yields one result.
    assign run_len = (sum_reg.data_count == 6'd0) ? 6'd1 : sum_reg.data_count;
    assign advance = rd_valid_reg && (!out_valid_reg || res.ready);
    assign issue   = run_active_reg && (!rd_valid_reg || advance);

    assign ram_re    = issue;
    assign ram_raddr = idx_reg[AW-1:0];
    assign busy      = run_active_reg || rd_valid_reg;

    always_comb
    begin
        run_active_next = run_active_reg;
        idx_next        = idx_reg;
        rd_last_next    = rd_last_reg;
        rd_valid_next   = rd_valid_reg;
        out_valid_next  = out_valid_reg;

        if (close_valid)
        begin
            run_active_next = 1'b1;
            idx_next        = '0;
        end
        else if (issue)
        begin
            idx_next     = idx_reg + 6'd1;
            rd_last_next = (idx_reg + 6'd1 == run_len);
            if (idx_reg + 6'd1 == run_len)
            begin
                run_active_next = 1'b0;
            end
        end

        if (issue)
        begin
            rd_valid_next = 1'b1;
        end
        else if (advance)
        begin
            rd_valid_next = 1'b0;
        end

        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_active_reg <= 1'b0;
            idx_reg        <= '0;
            rd_valid_reg   <= 1'b0;
            rd_last_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            run_active_reg <= run_active_next;
            idx_reg        <= idx_next;
            rd_valid_reg   <= rd_valid_next;
            rd_last_reg    <= rd_last_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (close_valid)
        begin
            sum_reg <= close_info;
        end
        if (advance)
        begin
            out_info_reg <= sum_reg;
            out_byte_reg <= (sum_reg.data_count != 6'd0) ? ram_rdata : 8'h00;
            out_last_reg <= rd_last_reg;
        end
    end

    assign res.valid          = out_valid_reg;
    assign res.verdict        = out_info_reg.verdict;
    assign res.gave_up        = out_info_reg.gave_up;
    assign res.direction      = out_info_reg.direction;
    assign res.command        = out_info_reg.command;
    assign res.size_field     = out_info_reg.size_field;
    assign res.value_field    = out_info_reg.value_field;
    assign res.status_present = out_info_reg.status_present;
    assign res.status_first   = out_info_reg.status_first;
    assign res.status_second  = out_info_reg.status_second;
    assign res.data_count     = out_info_reg.data_count;
    assign res.data_byte      = out_byte_reg;
    assign res.last_of_run    = out_last_reg;

endmodule

[hdl/slip_response_receiver_top.sv]
// Top level of the SLIP response receiver: configuration registers and glue.
// Depends on srr_pkg, the channel interfaces, srr_ram, srr_deframer, srr_run_gen and assert_macros.svh.
// Takes one byte per cycle while no run is in progress; frame bytes produce no result.
// A closing delimiter yields n results (1 to 32), the first via the buffer read and
// output register, then one per cycle while res.ready holds; rx stalls during the run.
// Asynchronous active-low reset clears framing state and attempt count and restores
// the default configuration; the data buffer is not cleared.
`include "assert_macros.svh"

module slip_response_receiver_top #(
    parameter int FRAME_CAPACITY = srr_pkg::FRAME_CAPACITY_DEF,
    parameter int DATA_CAPACITY  = srr_pkg::DATA_CAPACITY_DEF
) (
    input logic       clk,
    input logic       rst_n,
    srr_rx_if.sink    rx,
    srr_res_if.source res,
    srr_cfg_if.sink   cfg
);

    localparam int AW = $clog2(DATA_CAPACITY);

    srr_pkg::cfg_t   cfg_reg, cfg_next;
    logic            accept;
    logic            busy;
    logic            close_valid;
    srr_pkg::close_t close_info;
    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [7:0]      ram_wdata;
    logic            ram_re;
    logic [AW-1:0]   ram_raddr;
    logic [7:0]      ram_rdata;

    assign cfg.ready = 1'b1;
    assign rx.ready  = !busy;
    assign accept    = rx.valid && rx.ready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                srr_pkg::CFG_EXPECTED_COMMAND:     cfg_next.expected_command = cfg.data;
                srr_pkg::CFG_EXPECT_STATUS:        cfg_next.expect_status = cfg.data[0];
                srr_pkg::CFG_EXPECTED_DATA_LENGTH: cfg_next.expected_data_length = cfg.data[5:0];
                srr_pkg::CFG_MAX_ATTEMPTS:         cfg_next.max_attempts = cfg.data[3:0];
                default:                           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.expected_command     <= srr_pkg::EXPECTED_COMMAND_RST;
            cfg_reg.expect_status        <= srr_pkg::EXPECT_STATUS_RST;
            cfg_reg.expected_data_length <= srr_pkg::EXPECTED_DATA_LENGTH_RST;
            cfg_reg.max_attempts         <= srr_pkg::MAX_ATTEMPTS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    srr_deframer #(
        .FRAME_CAPACITY (FRAME_CAPACITY),
        .DATA_CAPACITY  (DATA_CAPACITY)
    ) u_deframer (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .accept      (accept),
        .rx_byte     (rx.rx_byte),
        .close_valid (close_valid),
        .close_info  (close_info),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata)
    );

    srr_ram #(
        .WIDTH (8),
        .DEPTH (DATA_CAPACITY)
    ) u_data_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    srr_run_gen #(
        .DATA_CAPACITY (DATA_CAPACITY)
    ) u_run_gen (
        .clk         (clk),
        .rst_n       (rst_n),
        .close_valid (close_valid),
        .close_info  (close_info),
        .busy        (busy),
        .ram_re      (ram_re),
        .ram_raddr   (ram_raddr),
        .ram_rdata   (ram_rdata),
        .res         (res)
    );

    `ASSERT_NEXT(a_close_stalls_input, clk, rst_n, close_valid, !rx.ready,
        "input not held after frame close")
    `ASSERT_IMPLIES(a_run_holds_input, clk, rst_n, res.valid && !res.last_of_run,
        !rx.ready, "input open inside a run")
    `ASSERT_IMPLIES(a_empty_run_single, clk, rst_n,
        res.valid && (res.data_count == 6'd0),
        res.last_of_run && (res.data_byte == 8'h00), "run without data not single")
    `ASSERT_IMPLIES(a_short_frame_zeroed, clk, rst_n,
        res.valid && (res.verdict == srr_pkg::VERDICT_TOO_SHORT),
        (res.direction == 8'h00) && (res.data_count == 6'd0) && !res.status_present,
        "short frame fields not cleared")

endmodule
